// File: design/logic_analyzer_trigger_capture_assert.svh
// Assertion macros shared by the capture design.
`ifndef LOGIC_ANALYZER_TRIGGER_CAPTURE_ASSERT_SVH
`define LOGIC_ANALYZER_TRIGGER_CAPTURE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define LAT_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define LAT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lat_pkg.sv
package lat_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PIN_W       = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [PIN_W-1:0] ALL_ONES = 8'hff;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ARM  = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_EDGE    = 2'd1,
        MODE_PATTERN = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_MODE    = 8'd0,
        REG_TRIGGER_CHANNEL = 8'd1,
        REG_TRIGGER_VALUE   = 8'd2,
        REG_TRIGGER_IGNORE  = 8'd3
    } t_reg_idx;

endpackage

// File: design/lat_if.sv
interface lat_in_if;
    import lat_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [PIN_W-1:0] sample_pins;

    modport source (output valid, output op, output sample_pins, input ready);
    modport sink (input valid, input op, input sample_pins, output ready);
endinterface

interface lat_out_if;
    import lat_pkg::*;
    logic             valid;
    logic             ready;
    logic             waiting;
    logic             stored;
    logic             full_res;
    logic [PIN_W-1:0] read_data;
    logic             read_valid;
    logic [CNT_W-1:0] fill_level;

    modport source (output valid, output waiting, output stored, output full_res,
                    output read_data, output read_valid, output fill_level,
                    input ready);
    modport sink (input valid, input waiting, input stored, input full_res,
                  input read_data, input read_valid, input fill_level,
                  output ready);
endinterface

interface lat_cfg_if;
    import lat_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/logic_analyzer_trigger_capture.sv
// Each item gives one result, shown in the cycle after its input transfer.
// Throughput: one item per cycle while the output is empty or accepted; the sample ring is a
// single memory, written by a stored tick and read by a read item in the same accept cycle.
// Reset (synchronous, active low) clears the trigger, pointers, count and output valid
// and returns the configuration to its defaults; the ring contents stay undefined until written.
`include "logic_analyzer_trigger_capture_assert.svh"

module logic_analyzer_trigger_capture (
    input  logic i_clk,
    input  logic i_rst_n,
    lat_in_if.sink    i_in,
    lat_cfg_if.sink   i_cfg,
    lat_out_if.source o_out
);
    import lat_pkg::*;

    logic [1:0]       r_cfg_mode;
    logic [3:0]       r_cfg_channel;
    logic [PIN_W-1:0] r_cfg_value;
    logic [PIN_W-1:0] r_cfg_ignore;

    t_mode            r_armed, n_armed;
    logic [PIN_W-1:0] r_prev, n_prev;
    logic             r_capturing, n_capturing;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic [PIN_W-1:0] r_mem [STORE_DEPTH];
    logic [PIN_W-1:0] r_mem_q;
    logic             mem_we, mem_re;

    logic             r_out_valid;
    logic             r_out_waiting, r_out_stored, r_out_full, r_out_rvalid;
    logic [CNT_W-1:0] r_out_fill;
    logic             n_stored, n_rvalid;

    logic             in_accept, cfg_accept, ring_full, fire;
    logic             ch_ok, was_bit, now_bit;
    logic [2:0]       ch_idx;

    logic             ptr_ok, read_hit, read_out, full_tick, full_held;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(STORE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STORE_DEPTH);

    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode    <= MODE_OFF;
            r_cfg_channel <= 4'd1;
            r_cfg_value   <= '0;
            r_cfg_ignore  <= '0;
        end else if (cfg_accept) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_TRIGGER_MODE:    r_cfg_mode    <= i_cfg.data[1:0];
                REG_TRIGGER_CHANNEL: r_cfg_channel <= i_cfg.data[3:0];
                REG_TRIGGER_VALUE:   r_cfg_value   <= i_cfg.data[PIN_W-1:0];
                REG_TRIGGER_IGNORE:  r_cfg_ignore  <= i_cfg.data[PIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign ring_full = (r_count == FULL_CNT);
    assign ch_ok     = (r_cfg_channel != 4'd0) && (r_cfg_channel <= 4'd8);
    assign ch_idx    = 3'(r_cfg_channel - 4'd1);
    assign was_bit   = ch_ok && r_prev[ch_idx];
    assign now_bit   = ch_ok && i_in.sample_pins[ch_idx];

    always_comb begin
        if (r_armed == MODE_EDGE) begin
            fire = (r_cfg_value == 8'd1) ? (now_bit && !was_bit) : (!now_bit && was_bit);
        end else begin
            fire = ((i_in.sample_pins | r_cfg_ignore) == (r_cfg_value | r_cfg_ignore));
        end
    end

    always_comb begin
        n_armed     = r_armed;
        n_prev      = r_prev;
        n_capturing = r_capturing;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_stored    = 1'b0;
        n_rvalid    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (t_op'(i_in.op))
            OP_ARM: begin
                n_armed     = (r_cfg_mode <= MODE_PATTERN) ? t_mode'(r_cfg_mode) : MODE_OFF;
                n_prev      = ALL_ONES;
                n_capturing = 1'b1;
            end
            OP_TICK: begin
                if (r_capturing) begin
                    if (ring_full) begin
                        n_capturing = 1'b0;
                    end else if (r_armed == MODE_EDGE) begin
                        if (fire) begin
                            n_armed = MODE_OFF;
                        end
                        n_prev = i_in.sample_pins;
                    end else if (r_armed == MODE_PATTERN) begin
                        if (fire) begin
                            n_armed = MODE_OFF;
                        end
                    end else begin
                        mem_we   = 1'b1;
                        n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
                        n_count  = r_count + 1'b1;
                        n_stored = 1'b1;
                        if (n_count == FULL_CNT) begin
                            n_capturing = 1'b0;
                        end
                    end
                end
            end
            OP_READ: begin
                if (r_count != '0) begin
                    mem_re   = 1'b1;
                    n_rvalid = 1'b1;
                    n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= MODE_OFF;
            r_prev      <= ALL_ONES;
            r_capturing <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_armed     <= n_armed;
                r_prev      <= n_prev;
                r_capturing <= n_capturing;
                r_wr_ptr    <= n_wr_ptr;
                r_rd_ptr    <= n_rd_ptr;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_waiting <= (n_armed != MODE_OFF);
            r_out_stored  <= n_stored;
            r_out_full    <= (n_count == FULL_CNT);
            r_out_rvalid  <= n_rvalid;
            r_out_fill    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && mem_we) begin
            r_mem[r_wr_ptr] <= i_in.sample_pins;
        end
        if (in_accept && mem_re) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.waiting    = r_out_waiting;
    assign o_out.stored     = r_out_stored;
    assign o_out.full_res   = r_out_full;
    assign o_out.read_valid = r_out_rvalid;
    assign o_out.read_data  = r_out_rvalid ? r_mem_q : '0;
    assign o_out.fill_level = r_out_fill;

    assign ptr_ok    = (PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_count));
    assign read_hit  = in_accept && (i_in.op == OP_READ) && (r_count != '0);
    assign read_out  = r_out_valid && r_out_rvalid;
    assign full_tick = in_accept && (i_in.op == OP_TICK) && ring_full;
    assign full_held = !r_capturing && !r_out_stored;

    `LAT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "count too large")
    `LAT_ASSERT_SAME(a_ptr_count, i_clk, i_rst_n, 1'b1, ptr_ok, "pointers disagree with count")
    `LAT_ASSERT_NEXT(a_read_hit, i_clk, i_rst_n, read_hit, read_out, "read of occupied ring lost")
    `LAT_ASSERT_NEXT(a_full_stop, i_clk, i_rst_n, full_tick, full_held, "capture ran on full ring")

endmodule
